/* rtl/core/hwg_pkg.sv */
// ----------------------------------------------------------------------------
// hwg_pkg
// Shared widths, command and pattern codes, and constants of the haptic
// waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package hwg_pkg;

	localparam int unsigned FREQ_W    = 12;
	localparam int unsigned INT_W     = 16;
	localparam int unsigned CNT_W     = 16;
	localparam int unsigned PAT_W     = 3;
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned FRAC_BITS = 15;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [PAT_W-1:0] PAT_CLICK = 3'd0;
	localparam logic [PAT_W-1:0] PAT_PULSE = 3'd2;
	localparam logic [PAT_W-1:0] PAT_SWEEP = 3'd3;

	localparam logic [CNT_W-1:0] CLICK_SAMPLES = 16'd80;

	// phase step divisors: sample rate, and the two sweep terms
	localparam longint unsigned SAMPLE_RATE_DIV  = 64'd8000;
	localparam longint unsigned SWEEP_STEP_DIV   = 64'd64000000;
	localparam longint unsigned SWEEP_GROWTH_DIV = 64'd32000000;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

`default_nettype wire

/* rtl/core/hwg_cdiv.sv */
// ----------------------------------------------------------------------------
// hwg_cdiv
// Rounded phase increment floor((f * 2^PHASE_BITS + DIVISOR/2) / DIVISOR)
// by reciprocal multiply and one correction, over three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_cdiv
	import hwg_pkg::*;
#(
	parameter int unsigned     PHASE_BITS = 32,
	parameter longint unsigned DIVISOR    = 64'd8000
) (
	input  wire logic                  clk,
	input  wire adv_t                  adv,
	input  wire logic [FREQ_W-1:0]     freq,
	output logic      [PHASE_BITS-1:0] quot
);

	function automatic int unsigned trail_zeros(input longint unsigned v);
		int unsigned n;
		n = 0;
		for (int i = 0; i < 64; i++) begin
			if (!v[i] && n == i)
				n = n + 1;
		end
		return n;
	endfunction

	localparam longint unsigned TURN  = 64'd1 << PHASE_BITS;
	localparam longint unsigned QD    = TURN / DIVISOR;
	localparam longint unsigned RD    = TURN % DIVISOR;
	localparam longint unsigned HALF  = DIVISOR / 2;
	localparam int unsigned     SH    = trail_zeros(DIVISOR);
	localparam longint unsigned OD    = DIVISOR >> SH;
	localparam int unsigned     WQD   = (QD > 0) ? $clog2(QD + 1) : 1;
	localparam int unsigned     WA    = (PHASE_BITS > FREQ_W + WQD) ? PHASE_BITS : FREQ_W + WQD;
	localparam int unsigned     WD    = $clog2(DIVISOR + 1);
	localparam int unsigned     WX    = FREQ_W + WD + 1;
	localparam int unsigned     WY    = $clog2(OD << FREQ_W);
	localparam longint unsigned RECIP = (64'd1 << WY) / OD;
	localparam int unsigned     WM    = $clog2(RECIP + 1);
	localparam int unsigned     WP    = WY + WM;

	localparam logic [WQD-1:0] QD_V    = WQD'(QD);
	localparam logic [WD-1:0]  RD_V    = WD'(RD);
	localparam logic [WX-1:0]  HALF_V  = WX'(HALF);
	localparam logic [WM-1:0]  RECIP_V = WM'(RECIP);
	localparam logic [WY:0]    OD_V    = (WY+1)'(OD);

	logic [WA-1:0]         a_full;
	logic [WX-1:0]         x_full;
	logic [PHASE_BITS-1:0] a_s2, a_s3;
	logic [WY-1:0]         y_s2, y_s3;
	logic [WP-1:0]         prod_s3;
	logic [FREQ_W-1:0]     q0, q_fix;
	logic [WY:0]           back, resid;
	logic [PHASE_BITS-1:0] quot_s4;

	assign a_full = WA'(freq) * WA'(QD_V);
	assign x_full = WX'(freq) * WX'(RD_V) + HALF_V;

	// estimate is low by at most one
	assign q0    = FREQ_W'(prod_s3 >> WY);
	assign back  = (WY+1)'(q0) * OD_V;
	assign resid = {1'b0, y_s3} - back;
	assign q_fix = (resid >= OD_V) ? q0 + 1'b1 : q0;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			a_s2 <= a_full[PHASE_BITS-1:0];
			y_s2 <= WY'(x_full >> SH);
		end
		if (adv.s3) begin
			a_s3    <= a_s2;
			y_s3    <= y_s2;
			prod_s3 <= WP'(y_s2) * WP'(RECIP_V);
		end
		if (adv.s4) begin
			quot_s4 <= a_s3 + PHASE_BITS'(q_fix);
		end
	end

	assign quot = quot_s4;

endmodule

`default_nettype wire

/* rtl/core/hwg_sine_rom.sv */
// ----------------------------------------------------------------------------
// hwg_sine_rom
// Sine ROM, Q1.15 entries built at elaboration by quadrant folding and a
// Q30 Taylor series; registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_sine_rom
	import hwg_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr,
	output logic signed [SAMPLE_W-1:0]               data
);

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	function automatic logic [SAMPLE_W-1:0] sine_val(input longint unsigned k);
		longint unsigned quad, rem, x, t, pos, neg, v;
		logic [SAMPLE_W-1:0] mag;
		quad = (4 * k) / SINE_TABLE_DEPTH;
		rem  = (4 * k) % SINE_TABLE_DEPTH;
		if (quad[0])
			rem = SINE_TABLE_DEPTH - rem;
		x   = (rem * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
		t   = x;
		pos = x;
		neg = 0;
		t   = ((((t * x) >> 30) * x) >> 30) / 6;
		neg = neg + t;
		t   = ((((t * x) >> 30) * x) >> 30) / 20;
		pos = pos + t;
		t   = ((((t * x) >> 30) * x) >> 30) / 42;
		neg = neg + t;
		t   = ((((t * x) >> 30) * x) >> 30) / 72;
		pos = pos + t;
		t   = ((((t * x) >> 30) * x) >> 30) / 110;
		neg = neg + t;
		v   = (pos > neg) ? pos - neg : 0;
		v   = (v * 32767 + (64'd1 << 29)) >> 30;
		if (v > 32767)
			v = 32767;
		mag = v[SAMPLE_W-1:0];
		return (quad >= 2) ? (~mag + 1'b1) : mag;
	endfunction

	logic [SAMPLE_W-1:0] rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic [SAMPLE_W-1:0] V = sine_val(k);
		assign rom[k] = V;
	end

	always_ff @(posedge clk) begin
		if (en)
			data <= $signed(rom[addr]);
	end

endmodule

`default_nettype wire

/* rtl/core/haptic_waveform_generator_top.sv */
// ----------------------------------------------------------------------------
// haptic_waveform_generator_top
// An accepted tick word passes registers s1 to s8 on its way to its sample.
// Throughput: one word per cycle unless out_ready stalls the chain; starts and ticks take effect in order.
// Start increments come from three reciprocal dividers (stages 2-4).
// Reset: idle, no event, enabled_q = 1; the sine ROM needs no fill.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_waveform_generator_top
	import hwg_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned PHASE_BITS       = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       command,
	input  wire logic [PAT_W-1:0]           pattern,
	input  wire logic [INT_W-1:0]           intensity,
	input  wire logic [FREQ_W-1:0]          frequency_hz,
	input  wire logic [CNT_W-1:0]           sample_count,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      sample,
	output logic                            last_sample,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic                       haptics_enabled
);

	localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned IW = PHASE_BITS + AW + 1;
	localparam int unsigned RW = INT_W + SAMPLE_W + 2;

	localparam logic [INT_W-1:0]       LEVEL_MAX = INT_W'(32767);
	localparam logic signed [RW-1:0]   RND_HALF  = RW'(1 << (FRAC_BITS - 1));
	localparam logic signed [RW-1:0]   SAT_HI    = RW'(32767);
	localparam logic signed [RW-1:0]   SAT_LO    = RW'(-32768);

	typedef struct packed {
		logic             cmd;
		logic [PAT_W-1:0] pat;
		logic [INT_W-1:0] level;
		logic [CNT_W-1:0] count;
	} item_t;

	// handshake chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic rdy_1, rdy_2, rdy_3, rdy_4, rdy_5, rdy_6, rdy_7, rdy_8;
	adv_t adv;

	item_t             item_s1, item_s2, item_s3, item_s4;
	logic [FREQ_W-1:0] freq_s1;

	logic [PHASE_BITS-1:0] base_step, sweep_add, sweep_grow;

	// event state
	logic                  enabled_q;
	logic [CNT_W-1:0]      left_q, index_q;
	logic [PHASE_BITS-1:0] phase_q, step_q, growth_q;
	logic [PAT_W-1:0]      act_pat_q;
	logic [INT_W-1:0]      act_level_q;

	logic                  is_sweep, gen;
	logic [PHASE_BITS-1:0] step_new, growth_new;

	logic [PHASE_BITS-1:0] phase_s5;
	logic [PAT_W-1:0]      pat_s5, pat_s6, pat_s7;
	logic [INT_W-1:0]      level_s5, level_s6, level_s7;
	logic                  click_s5, click_s6, click_s7;
	logic                  last_s5, last_s6, last_s7, last_s8;
	logic [AW-1:0]         idx_s6;
	logic [IW-1:0]         idx_full;
	logic signed [SAMPLE_W-1:0] entry_s7, sample_s8;

	logic [SAMPLE_W-1:0]           lvl_full;
	logic signed [INT_W:0]         lvl_sgn;
	logic signed [INT_W+SAMPLE_W:0] prod_w;
	logic signed [RW-1:0]          rnd_w, shf_w;
	logic [SAMPLE_W-1:0]           scaled, smp;

	assign rdy_8 = !v_s8 || out_ready;
	assign rdy_7 = !v_s7 || rdy_8;
	assign rdy_6 = !v_s6 || rdy_7;
	assign rdy_5 = !v_s5 || rdy_6;
	assign rdy_4 = !v_s4 || rdy_5;
	assign rdy_3 = !v_s3 || rdy_4;
	assign rdy_2 = !v_s2 || rdy_3;
	assign rdy_1 = !v_s1 || rdy_2;

	assign in_ready  = rdy_1;
	assign cfg_ready = 1'b1;
	assign adv.s2    = rdy_2;
	assign adv.s3    = rdy_3;
	assign adv.s4    = rdy_4;

	hwg_cdiv #(.PHASE_BITS(PHASE_BITS), .DIVISOR(SAMPLE_RATE_DIV)) u_div_base (
		.clk  (clk),
		.adv  (adv),
		.freq (freq_s1),
		.quot (base_step)
	);

	hwg_cdiv #(.PHASE_BITS(PHASE_BITS), .DIVISOR(SWEEP_STEP_DIV)) u_div_sweep (
		.clk  (clk),
		.adv  (adv),
		.freq (freq_s1),
		.quot (sweep_add)
	);

	hwg_cdiv #(.PHASE_BITS(PHASE_BITS), .DIVISOR(SWEEP_GROWTH_DIV)) u_div_grow (
		.clk  (clk),
		.adv  (adv),
		.freq (freq_s1),
		.quot (sweep_grow)
	);

	assign is_sweep   = item_s4.pat == PAT_SWEEP;
	assign step_new   = is_sweep ? base_step + sweep_add : base_step;
	assign growth_new = is_sweep ? sweep_grow : '0;
	assign gen        = item_s4.cmd == CMD_TICK && left_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy_1) v_s1 <= in_valid;
			if (rdy_2) v_s2 <= v_s1;
			if (rdy_3) v_s3 <= v_s2;
			if (rdy_4) v_s4 <= v_s3;
			if (rdy_5) v_s5 <= v_s4 && gen;
			if (rdy_6) v_s6 <= v_s5;
			if (rdy_7) v_s7 <= v_s6;
			if (rdy_8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b1;
			left_q      <= '0;
			index_q     <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			growth_q    <= '0;
			act_pat_q   <= '0;
			act_level_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready)
				enabled_q <= haptics_enabled;
			if (rdy_5 && v_s4) begin
				if (item_s4.cmd == CMD_START) begin
					if (enabled_q) begin
						act_pat_q   <= item_s4.pat;
						act_level_q <= item_s4.level;
						left_q      <= item_s4.count;
						index_q     <= '0;
						phase_q     <= '0;
						step_q      <= step_new;
						growth_q    <= growth_new;
					end
				end else if (left_q != '0) begin
					left_q   <= left_q - 1'b1;
					index_q  <= index_q + 1'b1;
					phase_q  <= phase_q + step_q;
					step_q   <= step_q + growth_q;
				end
			end
		end
	end

	assign idx_full = IW'(phase_s5) * IW'(SINE_TABLE_DEPTH);

	hwg_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk  (clk),
		.en   (rdy_7),
		.addr (idx_s6),
		.data (entry_s7)
	);

	// amplitude: round half up, floor shift, saturate
	assign lvl_full = (level_s7 > LEVEL_MAX) ? LEVEL_MAX : level_s7;
	assign lvl_sgn  = $signed({1'b0, level_s7});
	assign prod_w   = lvl_sgn * entry_s7;
	assign rnd_w    = RW'(prod_w) + RND_HALF;
	assign shf_w    = rnd_w >>> FRAC_BITS;
	assign scaled   = (shf_w > SAT_HI) ? SAT_HI[SAMPLE_W-1:0] :
	                  (shf_w < SAT_LO) ? SAT_LO[SAMPLE_W-1:0] : shf_w[SAMPLE_W-1:0];

	always_comb begin
		unique case (pat_s7)
			PAT_CLICK: smp = click_s7 ? lvl_full : '0;
			PAT_PULSE: smp = (entry_s7 > 16'sd0) ? lvl_full : '0;
			default:   smp = scaled;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_1) begin
			item_s1 <= '{cmd: command, pat: pattern, level: intensity, count: sample_count};
			freq_s1 <= frequency_hz;
		end
		if (rdy_2) item_s2 <= item_s1;
		if (rdy_3) item_s3 <= item_s2;
		if (rdy_4) item_s4 <= item_s3;
		if (rdy_5) begin
			phase_s5 <= phase_q;
			pat_s5   <= act_pat_q;
			level_s5 <= act_level_q;
			click_s5 <= index_q < CLICK_SAMPLES;
			last_s5  <= left_q == CNT_W'(1);
		end
		if (rdy_6) begin
			idx_s6   <= AW'(idx_full >> PHASE_BITS);
			pat_s6   <= pat_s5;
			level_s6 <= level_s5;
			click_s6 <= click_s5;
			last_s6  <= last_s5;
		end
		if (rdy_7) begin
			pat_s7   <= pat_s6;
			level_s7 <= level_s6;
			click_s7 <= click_s6;
			last_s7  <= last_s6;
		end
		if (rdy_8) begin
			sample_s8 <= $signed(smp);
			last_s8   <= last_s7;
		end
	end

	assign out_valid   = v_s8;
	assign sample      = sample_s8;
	assign last_sample = last_s8;

endmodule

`default_nettype wire

/* rtl/core/hwg_checker.sv */
// ----------------------------------------------------------------------------
// hwg_checker
// Port-level checks of the haptic waveform generator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hwg_checker
	import hwg_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   command,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic signed [SAMPLE_W-1:0] sample,
	input wire logic                   last_sample
);

	logic        tick_acc, out_acc;
	logic [31:0] surplus_q;

	assign tick_acc = in_valid && in_ready && command == CMD_TICK;
	assign out_acc  = out_valid && out_ready;

	// ticks taken minus samples delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			surplus_q <= '0;
		else
			surplus_q <= surplus_q + 32'(tick_acc) - 32'(out_acc);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last_sample))
		else $error("stalled output word changed");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_sample_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> surplus_q != '0)
		else $error("sample without a pending tick");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind haptic_waveform_generator_top hwg_checker u_hwg_checker (.*);

`default_nettype wire
